FILE: design/ssg_pkg.sv
// Package for the stepped-sweep sine generator: shared constants, types and
// the quarter-wave sine table entry function. No dependencies.
package ssg_pkg;

	// Default parameter values for the top level.
	localparam int DEF_BLOCK_MAX   = 1024;
	localparam int DEF_PHASE_BITS  = 32;
	localparam int DEF_TABLE_DEPTH = 256;
	localparam int QUEUE_DEPTH     = 4;

	// Fixed field widths.
	localparam int WORD_W      = 32;
	localparam int BLOCK_LEN_W = 11;
	localparam int SAMPLE_W    = 16;
	localparam int CFG_INDEX_W = 2;

	// Tuning word at half the sample rate, and pi/2 in Q2.30.
	localparam logic [WORD_W-1:0] NYQUIST_WORD = 32'h8000_0000;
	localparam logic [WORD_W-1:0] HALF_PI_Q30  = 32'd1686629713;

	// Register reset values.
	localparam logic [WORD_W-1:0]      START_WORD_RESET = 32'd97391263;
	localparam logic [WORD_W-1:0]      STEP_RESET       = 32'd0;
	localparam logic [BLOCK_LEN_W-1:0] BLOCK_LEN_RESET  = 11'd1024;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_START_WORD   = 2'd0,
		REG_TUNING_STEP  = 2'd1,
		REG_BLOCK_LENGTH = 2'd2
	} cfg_reg_t;

	// Per-sample bookkeeping that travels from the front end to the back end.
	typedef struct packed {
		logic              block_end;
		logic [WORD_W-1:0] block_number;
	} ssg_meta_t;

	// Quarter-wave entry k of a table with 2^log2d steps, Q1.15, saturated.
	// Evaluated at elaboration only: Taylor series of sine up to x^15 in Q30.
	function automatic logic [SAMPLE_W-1:0] sine_entry(input int unsigned k,
			input int unsigned log2d);
		logic [63:0]        x;
		logic [63:0]        term;
		logic signed [63:0] sum;
		logic signed [63:0] r;
		x    = (64'(HALF_PI_Q30) * 64'(k)) >> log2d;
		term = x;
		sum  = $signed(x);
		for (int n = 1; n <= 7; n++) begin
			term = (term * x) >> 30;
			term = (term * x) >> 30;
			// The term of order 2n+1 gains the factor 1/((2n)(2n+1)).
			case (n)
				1: term = term / 64'd6;
				2: term = term / 64'd20;
				3: term = term / 64'd42;
				4: term = term / 64'd72;
				5: term = term / 64'd110;
				6: term = term / 64'd156;
				default: term = term / 64'd210;
			endcase
			if (n[0]) begin
				sum = sum - $signed(term);
			end else begin
				sum = sum + $signed(term);
			end
		end
		if (sum < 0) begin
			sum = '0;
		end
		r = (sum + 64'sd16384) >>> 15;
		if (r > 64'sd32767) begin
			r = 64'sd32767;
		end
		return r[SAMPLE_W-1:0];
	endfunction

endpackage

FILE: design/ssg_if.sv
// Channel interfaces of the stepped-sweep sine generator: sample ticks,
// results and configuration writes. No dependencies.

// Sample tick channel.
interface ssg_tick_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

// Result channel.
interface ssg_result_if;
	logic                        valid;
	logic                        ready;
	logic signed [15:0]          sample;
	logic                        block_end;
	logic [31:0]                 block_number;

	modport source (output valid, output sample, output block_end, output block_number,
		input ready);
	modport sink (input valid, input sample, input block_end, input block_number,
		output ready);
endinterface

// Configuration write channel.
interface ssg_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: design/ssg_front.sv
// Front end of the sine generator: configuration registers, phase accumulator,
// tuning word sweep and block counting. Depends on ssg_pkg and ssg_if.
module ssg_front #(
	parameter int BLOCK_MAX   = ssg_pkg::DEF_BLOCK_MAX,
	parameter int PHASE_BITS  = ssg_pkg::DEF_PHASE_BITS,
	parameter int TABLE_DEPTH = ssg_pkg::DEF_TABLE_DEPTH,
	localparam int POS_W      = 2 + $clog2(TABLE_DEPTH)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	ssg_tick_if.sink              tick,
	ssg_cfg_if.sink               cfg,
	output logic                  push_valid,
	output logic [POS_W-1:0]      push_pos,
	output ssg_pkg::ssg_meta_t    push_meta,
	input  logic                  push_ready
);
	import ssg_pkg::*;

	localparam int CNT_W  = $clog2(BLOCK_MAX);
	localparam int LEN_W  = (CNT_W + 1 > BLOCK_LEN_W) ? CNT_W + 1 : BLOCK_LEN_W;
	localparam int WIDE_W = (PHASE_BITS > WORD_W) ? PHASE_BITS : WORD_W;
	localparam int UP     = (PHASE_BITS >= WORD_W) ? PHASE_BITS - WORD_W : 0;
	localparam int DOWN   = (PHASE_BITS < WORD_W) ? WORD_W - PHASE_BITS : 0;

	logic [WORD_W-1:0]      start_q;
	logic [WORD_W-1:0]      step_q;
	logic [BLOCK_LEN_W-1:0] blen_q;

	logic [PHASE_BITS-1:0]  phase_q;
	logic [WORD_W-1:0]      tuning_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [WORD_W-1:0]      blocks_q;

	logic                   accept;
	logic [WORD_W-1:0]      start_clamped;
	logic [PHASE_BITS-1:0]  cur_phase;
	logic [WORD_W-1:0]      cur_tuning;
	logic [CNT_W-1:0]       cur_cnt;
	logic [WORD_W-1:0]      cur_blocks;
	logic [LEN_W-1:0]       cnt_next;
	logic [LEN_W-1:0]       len;
	logic                   blk_end;
	logic [WORD_W-1:0]      blocks_next;
	logic signed [WORD_W+1:0] stepped;
	logic [WORD_W-1:0]      tuning_stepped;
	logic [WIDE_W-1:0]      inc_wide;
	logic [PHASE_BITS-1:0]  inc;

	// Configuration writes are always taken; unknown indexes are dropped.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= START_WORD_RESET;
			step_q  <= STEP_RESET;
			blen_q  <= BLOCK_LEN_RESET;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_START_WORD:   start_q <= cfg.data;
				REG_TUNING_STEP:  step_q  <= cfg.data;
				REG_BLOCK_LENGTH: blen_q  <= cfg.data[BLOCK_LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Restart applies before the sample of the same transaction is produced.
	assign accept        = tick.valid && tick.ready;
	assign tick.ready    = push_ready;
	assign start_clamped = (start_q > NYQUIST_WORD) ? NYQUIST_WORD : start_q;
	assign cur_phase     = tick.restart ? '0 : phase_q;
	assign cur_tuning    = tick.restart ? start_clamped : tuning_q;
	assign cur_cnt       = tick.restart ? '0 : cnt_q;
	assign cur_blocks    = tick.restart ? '0 : blocks_q;

	// Block length is clamped to 1 .. BLOCK_MAX.
	always_comb begin
		if (blen_q == '0) begin
			len = LEN_W'(1);
		end else if (LEN_W'(blen_q) > LEN_W'(BLOCK_MAX)) begin
			len = LEN_W'(BLOCK_MAX);
		end else begin
			len = LEN_W'(blen_q);
		end
	end

	assign cnt_next    = LEN_W'(cur_cnt) + LEN_W'(1);
	assign blk_end     = cnt_next >= len;
	assign blocks_next = cur_blocks + WORD_W'(blk_end);

	// Signed step, saturated to 0 .. Nyquist.
	assign stepped = $signed({2'b00, cur_tuning}) + (WORD_W+2)'($signed(step_q));
	always_comb begin
		if (stepped < 0) begin
			tuning_stepped = '0;
		end else if (stepped > $signed({2'b00, NYQUIST_WORD})) begin
			tuning_stepped = NYQUIST_WORD;
		end else begin
			tuning_stepped = stepped[WORD_W-1:0];
		end
	end

	// Phase increment scaled from the 32-bit tuning word to the phase width.
	assign inc_wide = WIDE_W'(cur_tuning) << UP;
	assign inc      = PHASE_BITS'(inc_wide >> DOWN);

	// Queue entry: quadrant and table index, plus block bookkeeping.
	assign push_valid          = tick.valid;
	assign push_pos            = cur_phase[PHASE_BITS-1 -: POS_W];
	assign push_meta.block_end = blk_end;
	assign push_meta.block_number = blocks_next;

	// State update per accepted tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= '0;
			tuning_q <= START_WORD_RESET;
			cnt_q    <= '0;
			blocks_q <= '0;
		end else if (accept) begin
			phase_q  <= cur_phase + inc;
			tuning_q <= blk_end ? tuning_stepped : cur_tuning;
			cnt_q    <= blk_end ? '0 : cnt_next[CNT_W-1:0];
			blocks_q <= blocks_next;
		end
	end

	a_tuning_range: assert property (@(posedge clk) disable iff (!arst_n)
		tuning_q <= NYQUIST_WORD)
		else $error("tuning word above Nyquist");

	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && tick.restart && !blk_end |=> blocks_q == '0 && cnt_q == CNT_W'(1))
		else $error("restart did not clear the block counters");

endmodule

FILE: design/ssg_queue.sv
// Short queue between the front end and the back end of the sine generator.
// Depends on ssg_pkg only through the default depth.
module ssg_queue #(
	parameter int W     = 8,
	parameter int DEPTH = ssg_pkg::QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	input  logic [W-1:0] push_data,
	output logic         push_ready,
	output logic         pop_valid,
	output logic [W-1:0] pop_data,
	input  logic         pop_ready
);
	import ssg_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Storage is written in place; only pointers and count are reset.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers wrap at DEPTH.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count exceeds depth");

	a_count_grows: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("queue lost a transaction");

endmodule

FILE: design/ssg_back.sv
// Back end of the sine generator: quarter-wave table lookup and the result
// output register. Depends on ssg_pkg and ssg_if.
module ssg_back #(
	parameter int TABLE_DEPTH = ssg_pkg::DEF_TABLE_DEPTH,
	localparam int POS_W      = 2 + $clog2(TABLE_DEPTH)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pop_valid,
	input  logic [POS_W-1:0]      pop_pos,
	input  ssg_pkg::ssg_meta_t    pop_meta,
	output logic                  pop_ready,
	ssg_result_if.source          result
);
	import ssg_pkg::*;

	localparam int IDX_W  = $clog2(TABLE_DEPTH);
	localparam int ADDR_W = IDX_W + 1;

	logic [SAMPLE_W-1:0]     sine_rom [TABLE_DEPTH + 1];
	logic [1:0]              quad;
	logic [IDX_W-1:0]        idx;
	logic [ADDR_W-1:0]       addr;
	logic [SAMPLE_W-1:0]     mag;
	logic signed [SAMPLE_W-1:0] sample_next;
	logic                    pop;

	logic                    valid_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	ssg_meta_t               meta_q;

	// Constant quarter-wave table, entries 0 .. TABLE_DEPTH.
	for (genvar k = 0; k <= TABLE_DEPTH; k++) begin : g_rom
		localparam logic [SAMPLE_W-1:0] ENTRY = sine_entry(k, IDX_W);
		assign sine_rom[k] = ENTRY;
	end

	// Quadrants 1 and 3 read the table backwards; 2 and 3 negate.
	assign quad        = pop_pos[POS_W-1 -: 2];
	assign idx         = pop_pos[IDX_W-1:0];
	assign addr        = quad[0] ? (ADDR_W'(TABLE_DEPTH) - {1'b0, idx}) : {1'b0, idx};
	assign mag         = sine_rom[addr];
	assign sample_next = quad[1] ? -$signed(mag) : $signed(mag);

	// Output register: refills when empty or when its transaction is taken.
	assign pop_ready = !valid_q || result.ready;
	assign pop       = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop_ready) begin
			valid_q <= pop_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			sample_q <= sample_next;
			meta_q   <= pop_meta;
		end
	end

	assign result.valid        = valid_q;
	assign result.sample       = sample_q;
	assign result.block_end    = meta_q.block_end;
	assign result.block_number = meta_q.block_number;

	a_sample_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> sample_q != 16'sh8000)
		else $error("sample outside Q1.15 range");

endmodule

FILE: design/stepped_sweep_sine_generator.sv
// Stepped-sweep sine generator: one sine sample per tick from a phase
// accumulator and a quarter-wave table, with a stepped tuning-word sweep.
// Throughput: one tick per cycle while the queue is not full, limited by the state update.
// Path: an accepted tick is written into the queue, then read through the table
// lookup into the output register, which holds it while the receiver stalls.
// Reset: arst_n clears phase, counters and queue and restores the configuration registers.
module stepped_sweep_sine_generator #(
	parameter int BLOCK_MAX   = ssg_pkg::DEF_BLOCK_MAX,
	parameter int PHASE_BITS  = ssg_pkg::DEF_PHASE_BITS,
	parameter int TABLE_DEPTH = ssg_pkg::DEF_TABLE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	ssg_tick_if.sink      tick,
	ssg_result_if.source  result,
	ssg_cfg_if.sink       cfg
);
	import ssg_pkg::*;

	localparam int POS_W   = 2 + $clog2(TABLE_DEPTH);
	localparam int ENTRY_W = POS_W + $bits(ssg_meta_t);

	logic               push_valid;
	logic               push_ready;
	logic [POS_W-1:0]   push_pos;
	ssg_meta_t          push_meta;
	logic               pop_valid;
	logic               pop_ready;
	logic [ENTRY_W-1:0] pop_data;
	logic [POS_W-1:0]   pop_pos;
	ssg_meta_t          pop_meta;

	// Front end: state update per tick.
	ssg_front #(
		.BLOCK_MAX  (BLOCK_MAX),
		.PHASE_BITS (PHASE_BITS),
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (tick),
		.cfg       (cfg),
		.push_valid(push_valid),
		.push_pos  (push_pos),
		.push_meta (push_meta),
		.push_ready(push_ready)
	);

	// Queue decoupling the two halves.
	ssg_queue #(
		.W    (ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_data ({push_pos, push_meta}),
		.push_ready(push_ready),
		.pop_valid (pop_valid),
		.pop_data  (pop_data),
		.pop_ready (pop_ready)
	);

	assign pop_pos  = pop_data[ENTRY_W-1 -: POS_W];
	assign pop_meta = pop_data[$bits(ssg_meta_t)-1:0];

	// Back end: table lookup and output register.
	ssg_back #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_pos  (pop_pos),
		.pop_meta (pop_meta),
		.pop_ready(pop_ready),
		.result   (result)
	);

endmodule

FILE: sim/stepped_sweep_sine_generator_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the stepped-sweep sine generator: drives sample ticks and
// register writes, predicts every sample, block flag and block count, and checks them.
// Depends on ssg_pkg, the channel interfaces in ssg_if.sv and the top level.
module stepped_sweep_sine_generator_tb;
	import ssg_pkg::*;

	localparam int TAB_DEPTH = DEF_TABLE_DEPTH;

	// Index 3 has no register behind it; writes to it must be ignored.
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

	// One expected result transaction.
	typedef struct {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       block_end;
		logic [WORD_W-1:0]          block_number;
	} sine_result_t;

	logic clk;
	logic arst_n;

	ssg_tick_if   tick_bus ();
	ssg_result_if res_bus ();
	ssg_cfg_if    cfg_bus ();

	stepped_sweep_sine_generator uut (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick_bus),
		.result (res_bus),
		.cfg    (cfg_bus)
	);

	// Quarter-wave table of the predictor, Q1.15.
	int sine_q15 [0:TAB_DEPTH];

	// Predictor copy of the registers and of the oscillator state.
	logic [WORD_W-1:0]      reg_start  = START_WORD_RESET;
	logic [WORD_W-1:0]      reg_step   = STEP_RESET;
	logic [BLOCK_LEN_W-1:0] reg_len    = BLOCK_LEN_RESET;
	logic [WORD_W-1:0]      osc_phase  = '0;
	logic [WORD_W-1:0]      osc_word   = START_WORD_RESET;
	int                     osc_count  = 0;
	logic [WORD_W-1:0]      osc_blocks = '0;

	sine_result_t expected_samples [$];
	int           err_count     = 0;
	bit           tx_idle_on    = 1'b1;
	bit           rx_idle_on    = 1'b1;
	int           rx_hold_cycles = 0;

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever begin
			#5 clk = ~clk;
		end
	end

	// Global watchdog.
	initial begin
		#3_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// Advance the oscillator by one tick and queue the sample it produces.
	function automatic void advance_oscillator(input logic restart_flag);
		sine_result_t r;
		logic [63:0]  scaled;
		int           idx;
		int           len;
		longint       next_word;
		longint       step_s;
		longint       cap;
		if (restart_flag) begin
			osc_phase  = '0;
			osc_word   = (reg_start > NYQUIST_WORD) ? NYQUIST_WORD : reg_start;
			osc_count  = 0;
			osc_blocks = '0;
		end
		// Quadrant from the top two phase bits, table index from the rest.
		scaled = 64'(osc_phase[WORD_W-3:0]) * TAB_DEPTH;
		idx    = int'(scaled >> (WORD_W - 2));
		case (osc_phase[WORD_W-1:WORD_W-2])
			2'd0: r.sample = SAMPLE_W'(sine_q15[idx]);
			2'd1: r.sample = SAMPLE_W'(sine_q15[TAB_DEPTH - idx]);
			2'd2: r.sample = SAMPLE_W'(-sine_q15[idx]);
			default: r.sample = SAMPLE_W'(-sine_q15[TAB_DEPTH - idx]);
		endcase
		osc_phase = osc_phase + osc_word;
		// Effective block length is clamped to 1 .. BLOCK_MAX.
		len = int'(reg_len);
		if (len == 0) begin
			len = 1;
		end
		if (len > DEF_BLOCK_MAX) begin
			len = DEF_BLOCK_MAX;
		end
		osc_count++;
		r.block_end = 1'b0;
		if (osc_count >= len) begin
			next_word = osc_word;
			step_s    = $signed(reg_step);
			cap       = NYQUIST_WORD;
			next_word = next_word + step_s;
			if (next_word < 0) begin
				next_word = 0;
			end
			if (next_word > cap) begin
				next_word = cap;
			end
			osc_word    = next_word[WORD_W-1:0];
			osc_count   = 0;
			osc_blocks  = osc_blocks + 1;
			r.block_end = 1'b1;
		end
		r.block_number = osc_blocks;
		expected_samples.push_back(r);
	endfunction

	// Send one tick transaction; valid stays high afterwards for back-to-back ticks.
	task automatic send_tick(input logic restart_flag);
		int gap;
		gap = tx_idle_on ? $urandom_range(0, 8) : 0;
		@(negedge clk);
		if (gap > 0) begin
			tick_bus.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		tick_bus.valid   = 1'b1;
		tick_bus.restart = restart_flag;
		do begin
			@(posedge clk);
		end while (!tick_bus.ready);
		advance_oscillator(restart_flag);
	endtask

	// Stop sending and wait until every expected sample has been checked.
	task automatic drain_results();
		@(negedge clk);
		tick_bus.valid = 1'b0;
		while (expected_samples.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	// Write one register while the block is idle.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [WORD_W-1:0] data);
		drain_results();
		@(negedge clk);
		cfg_bus.valid = 1'b1;
		cfg_bus.index = index;
		cfg_bus.data  = data;
		do begin
			@(posedge clk);
		end while (!cfg_bus.ready);
		case (index)
			REG_START_WORD:   reg_start = data;
			REG_TUNING_STEP:  reg_step  = data;
			REG_BLOCK_LENGTH: reg_len   = data[BLOCK_LEN_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_bus.valid = 1'b0;
	endtask

	// Receiver: random stalls per transaction, plus a long hold-off on request.
	initial begin
		int gap;
		res_bus.ready = 1'b0;
		forever begin
			gap = rx_idle_on ? $urandom_range(0, 8) : 0;
			@(negedge clk);
			if (rx_hold_cycles > 0) begin
				res_bus.ready = 1'b0;
				repeat (rx_hold_cycles) @(negedge clk);
				rx_hold_cycles = 0;
			end else if (gap > 0) begin
				res_bus.ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			res_bus.ready = 1'b1;
			do begin
				@(posedge clk);
			end while (!res_bus.valid);
		end
	end

	// Compare each result transaction with the oldest expected sample.
	always @(posedge clk) begin : result_check
		sine_result_t want;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			if (expected_samples.size() == 0) begin
				$display("%0t: unexpected result, sample %0d block_end %0b block_number %0d",
					$time, res_bus.sample, res_bus.block_end, res_bus.block_number);
				err_count++;
			end else begin
				want = expected_samples.pop_front();
				if (res_bus.sample !== want.sample) begin
					$display("%0t: sample mismatch, expected %0d actual %0d",
						$time, want.sample, res_bus.sample);
					err_count++;
				end
				if (res_bus.block_end !== want.block_end) begin
					$display("%0t: block_end mismatch, expected %0b actual %0b",
						$time, want.block_end, res_bus.block_end);
					err_count++;
				end
				if (res_bus.block_number !== want.block_number) begin
					$display("%0t: block_number mismatch, expected %0d actual %0d",
						$time, want.block_number, res_bus.block_number);
					err_count++;
				end
			end
		end
	end

	// Free-running ticks from the reset state, then a restart.
	task automatic test_reset_defaults();
		send_tick(1'b0);
		send_tick(1'b0);
		send_tick(1'b1);
	endtask

	// Start words at zero, at Nyquist, above Nyquist and at a quarter turn per tick.
	task automatic test_tuning_extremes();
		write_reg(REG_START_WORD, 32'h0000_0000);
		send_tick(1'b1);
		send_tick(1'b0);
		write_reg(REG_START_WORD, NYQUIST_WORD);
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b0);
		write_reg(REG_START_WORD, 32'hFFFF_FFFF);
		send_tick(1'b1);
		send_tick(1'b0);
		// A quarter turn per tick visits all four quadrants and the table ends.
		write_reg(REG_START_WORD, 32'h4000_0000);
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b0);
		send_tick(1'b0);
		// A write to the unused index must change nothing.
		write_reg(REG_UNUSED, $urandom);
		send_tick(1'b0);
	endtask

	// Zero length, step saturation at Nyquist, a step down to exactly zero, and a length lowered mid-block.
	task automatic test_block_lengths();
		write_reg(REG_BLOCK_LENGTH, 32'd0);
		write_reg(REG_TUNING_STEP, 32'h7FFF_FFFF);
		write_reg(REG_START_WORD, 32'h1000_0000);
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b0);
		write_reg(REG_TUNING_STEP, 32'h8000_0000);
		send_tick(1'b0);
		write_reg(REG_TUNING_STEP, 32'h0010_0000);
		write_reg(REG_BLOCK_LENGTH, 32'd8);
		repeat (5) send_tick(1'b0);
		send_tick(1'b1);
		write_reg(REG_BLOCK_LENGTH, 32'd3);
		send_tick(1'b0);
	endtask

	// Receiver holds off long enough for the block to fill and stall its input.
	task automatic test_input_stall();
		tx_idle_on     = 1'b0;
		rx_hold_cycles = 50;
		repeat (20) send_tick(1'b0);
		drain_results();
		tx_idle_on = 1'b1;
	endtask

	// Sender pauses until all samples are out, then continues the same sweep.
	task automatic test_sender_pause();
		repeat (30) send_tick(1'b0);
		drain_results();
		repeat (30) send_tick(1'b0);
	endtask

	// Lengths above the maximum act as full-size blocks.
	task automatic test_block_cap();
		write_reg(REG_BLOCK_LENGTH, 32'd2047);
		write_reg(REG_TUNING_STEP, 32'd1000000);
		write_reg(REG_START_WORD, $urandom_range(0, 32'h1000_0000));
		rx_idle_on = 1'b0;
		tx_idle_on = 1'b0;
		send_tick(1'b1);
		repeat (1029) send_tick($urandom_range(0, 511) == 0);
		rx_idle_on = 1'b1;
		tx_idle_on = 1'b1;
	endtask

	// Random register settings, each followed by a run of random ticks.
	task automatic test_random_sweeps();
		logic [WORD_W-1:0] start_w;
		logic [WORD_W-1:0] step_w;
		logic [WORD_W-1:0] len_w;
		for (int phase_n = 0; phase_n < 10; phase_n++) begin
			case ($urandom_range(0, 7))
				0: start_w = '0;
				1: start_w = NYQUIST_WORD;
				2: start_w = $urandom;
				default: start_w = $urandom_range(0, 32'h0800_0000);
			endcase
			case ($urandom_range(0, 5))
				0: step_w = $urandom;
				1: step_w = '0;
				default: step_w = $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
			endcase
			case ($urandom_range(0, 9))
				0: len_w = 32'd0;
				1: len_w = 32'd1024;
				2: len_w = $urandom;
				default: len_w = $urandom_range(1, 24);
			endcase
			write_reg(REG_START_WORD, start_w);
			write_reg(REG_TUNING_STEP, step_w);
			write_reg(REG_BLOCK_LENGTH, len_w);
			if ($urandom_range(0, 3) == 0) begin
				write_reg(REG_UNUSED, $urandom);
			end
			tx_idle_on = ($urandom_range(0, 3) != 0);
			rx_idle_on = ($urandom_range(0, 3) != 0);
			send_tick($urandom_range(0, 1) == 1);
			repeat (89) send_tick($urandom_range(0, 31) == 0);
		end
	endtask

	// Main sequence.
	initial begin
		logic [63:0] ang;
		logic [63:0] pw;
		longint      acc;
		longint      rnd;
		// Quarter-wave table by Taylor series in Q30, rounded to Q1.15.
		for (int k = 0; k <= TAB_DEPTH; k++) begin
			ang = (64'(HALF_PI_Q30) * k) / TAB_DEPTH;
			pw  = ang;
			acc = ang;
			for (int n = 1; n <= 7; n++) begin
				pw = (pw * ang) >> 30;
				pw = (pw * ang) >> 30;
				pw = pw / ((2 * n) * (2 * n + 1));
				if (n % 2 == 1) begin
					acc = acc - longint'(pw);
				end else begin
					acc = acc + longint'(pw);
				end
			end
			if (acc < 0) begin
				acc = 0;
			end
			rnd = (acc + 16384) / 32768;
			if (rnd > 32767) begin
				rnd = 32767;
			end
			sine_q15[k] = int'(rnd);
		end

		arst_n           = 1'b0;
		tick_bus.valid   = 1'b0;
		tick_bus.restart = 1'b0;
		cfg_bus.valid    = 1'b0;
		cfg_bus.index    = REG_START_WORD;
		cfg_bus.data     = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_tuning_extremes();
		test_block_lengths();
		test_input_stall();
		test_sender_pause();
		test_block_cap();
		test_random_sweeps();
		drain_results();
		repeat (10) @(posedge clk);

		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

FILE: files.f
design/ssg_pkg.sv
design/ssg_if.sv
design/ssg_front.sv
design/ssg_queue.sv
design/ssg_back.sv
design/stepped_sweep_sine_generator.sv
sim/stepped_sweep_sine_generator_tb.sv
